### sv/lphm_pkg.sv
package lphm_pkg;

    localparam int TABLE_SIZE_DEF = 256;

    // Hash bits folded into the start slot per cycle when the table size is
    // not a power of two.
    localparam int MOD_BITS = 4;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_PUT    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_ABSENT   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_NULLKEY  = 3'd5;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key_id;
        logic [31:0] key_hash;
        logic [63:0] value_in;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [63:0] value_out;
        logic [7:0]  slot_index;
        logic [8:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic clear;
        logic load;
        logic mod_step;
        logic probe;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic direct;
        logic mod_done;
        logic probe_stop;
        logic out_free;
    } t_dp_sts;

endpackage

### sv/lphm_ctrl.sv
module lphm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lphm_pkg::t_dp_sts i_sts,
    output lphm_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_MOD    = 5'b00100,
        S_PROBE  = 5'b01000,
        S_COMMIT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.direct ? S_PROBE : S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) n_state = S_PROBE;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_sts.probe_stop) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### sv/lphm_dp.sv
module lphm_dp #(
    parameter int TABLE_SIZE = lphm_pkg::TABLE_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lphm_pkg::t_req    i_in,
    input  lphm_pkg::t_dp_cmd i_cmd,
    output lphm_pkg::t_dp_sts o_sts,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output lphm_pkg::t_rsp    o_out
);

    localparam int IW        = $clog2(TABLE_SIZE);
    localparam int CW        = $clog2(TABLE_SIZE + 1);
    localparam int RW        = IW + 1;
    localparam bit POW2      = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    localparam int MOD_STEPS = 32 / lphm_pkg::MOD_BITS;
    localparam int MW        = $clog2(MOD_STEPS);
    localparam logic [IW-1:0] LAST      = IW'(TABLE_SIZE - 1);
    localparam logic [RW-1:0] MODULUS   = RW'(TABLE_SIZE);
    localparam logic [MW-1:0] MOD_LAST  = MW'(MOD_STEPS - 1);

    // Slot stores. Only the tag store has a defined reset, done by a sweep.
    logic [1:0]  r_tag_mem [TABLE_SIZE];
    logic [31:0] r_key_mem [TABLE_SIZE];
    logic [63:0] r_val_mem [TABLE_SIZE];
    logic [1:0]  r_rd_tag;
    logic [31:0] r_rd_key;
    logic [63:0] r_rd_val;

    // Request.
    logic [1:0]  r_op;
    logic [31:0] r_key;
    logic [63:0] r_val;
    logic        r_null;

    // Start slot remainder.
    logic [31:0]   r_hsh;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] n_rem;
    logic [MW-1:0] r_mcnt;

    // Probe state.
    logic [IW-1:0] r_ix;
    logic [IW-1:0] r_chk;
    logic [IW-1:0] r_n;
    logic          r_rd_ok;
    logic          r_spare_ok;
    logic [IW-1:0] r_spare;
    logic          r_hit;
    logic          r_pos_ok;
    logic [IW-1:0] r_pos;
    logic [63:0]   r_hit_val;

    logic [IW-1:0] r_clr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    lphm_pkg::t_rsp r_out;
    lphm_pkg::t_rsp n_out;

    logic          live_hit;
    logic          is_empty;
    logic          spare_ok_n;
    logic [IW-1:0] spare_n;
    logic          stop;
    logic [IW-1:0] ix_inc;

    logic          tag_we;
    logic          key_we;
    logic          val_we;
    logic [IW-1:0] wr_addr;
    logic [1:0]    tag_wd;
    logic [63:0]   val_wd;

    always_comb begin
        n_rem = r_rem;
        for (int b = 0; b < lphm_pkg::MOD_BITS; b++) begin
            n_rem = {n_rem[RW-2:0], r_hsh[31-b]};
            if (n_rem >= MODULUS) n_rem = n_rem - MODULUS;
        end
    end

    assign ix_inc     = (r_ix == LAST) ? '0 : r_ix + 1'b1;
    assign live_hit   = (r_rd_tag == lphm_pkg::TAG_LIVE) && (r_rd_key == r_key);
    assign is_empty   = (r_rd_tag == lphm_pkg::TAG_EMPTY);
    // Anything neither live nor empty counts as a tombstone.
    assign spare_ok_n = r_spare_ok || (!is_empty && (r_rd_tag != lphm_pkg::TAG_LIVE));
    assign spare_n    = r_spare_ok ? r_spare : r_chk;
    assign stop       = r_null || (r_rd_ok && (live_hit || is_empty || (r_n == LAST)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_in.cmd;
            r_key  <= i_in.key_id;
            r_val  <= i_in.value_in;
            r_null <= (i_in.key_id == 32'd0);
            r_hsh  <= i_in.key_hash;
            r_rem  <= '0;
            r_mcnt <= '0;
            r_n    <= '0;
            r_spare_ok <= 1'b0;
            if (POW2) r_ix <= i_in.key_hash[IW-1:0];
        end
        if (i_cmd.mod_step) begin
            r_rem  <= n_rem;
            r_hsh  <= r_hsh << lphm_pkg::MOD_BITS;
            r_mcnt <= r_mcnt + 1'b1;
            if (r_mcnt == MOD_LAST) r_ix <= n_rem[IW-1:0];
        end
        if (i_cmd.probe) begin
            r_ix  <= ix_inc;
            r_chk <= r_ix;
            if (r_rd_ok) begin
                r_n        <= r_n + 1'b1;
                r_spare_ok <= spare_ok_n;
                r_spare    <= spare_n;
            end
            if (stop) begin
                r_hit     <= r_rd_ok && !r_null && live_hit;
                r_pos_ok  <= live_hit || is_empty || spare_ok_n;
                r_pos     <= live_hit ? r_chk : spare_n;
                r_hit_val <= r_rd_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.load)  r_rd_ok <= 1'b0;
            if (i_cmd.probe) r_rd_ok <= !stop;
            if (i_cmd.clear) r_clr   <= r_clr + 1'b1;
        end
    end

    always_comb begin
        n_out             = '0;
        n_out.status      = lphm_pkg::ST_ABSENT;
        n_count           = r_count;
        tag_we            = 1'b0;
        key_we            = 1'b0;
        val_we            = 1'b0;
        tag_wd            = lphm_pkg::TAG_EMPTY;
        val_wd            = r_val;
        if (r_null) begin
            n_out.status = lphm_pkg::ST_NULLKEY;
        end else begin
            case (r_op)
                lphm_pkg::OP_PUT: begin
                    if (r_hit) begin
                        val_we           = 1'b1;
                        n_out.status     = lphm_pkg::ST_UPDATED;
                        n_out.found      = 1'b1;
                        n_out.slot_index = 8'(r_pos);
                    end else if (!r_pos_ok) begin
                        n_out.status = lphm_pkg::ST_FULL;
                    end else begin
                        tag_we           = 1'b1;
                        key_we           = 1'b1;
                        val_we           = 1'b1;
                        tag_wd           = lphm_pkg::TAG_LIVE;
                        n_count          = r_count + 1'b1;
                        n_out.status     = lphm_pkg::ST_INSERTED;
                        n_out.slot_index = 8'(r_pos);
                    end
                end
                lphm_pkg::OP_REMOVE: begin
                    if (r_hit) begin
                        tag_we           = 1'b1;
                        val_we           = 1'b1;
                        tag_wd           = lphm_pkg::TAG_TOMB;
                        val_wd           = 64'd0;
                        n_count          = r_count - 1'b1;
                        n_out.status     = lphm_pkg::ST_REMOVED;
                        n_out.found      = 1'b1;
                        n_out.slot_index = 8'(r_pos);
                    end
                end
                default: begin
                    if (r_hit) begin
                        n_out.status     = lphm_pkg::ST_UPDATED;
                        n_out.found      = 1'b1;
                        n_out.value_out  = r_hit_val;
                        n_out.slot_index = 8'(r_pos);
                    end
                end
            endcase
        end
        n_out.entry_count = 9'(n_count);
        if (i_cmd.clear) begin
            tag_we = 1'b1;
            tag_wd = lphm_pkg::TAG_EMPTY;
        end else if (!i_cmd.commit) begin
            tag_we = 1'b0;
            key_we = 1'b0;
            val_we = 1'b0;
        end
    end

    assign wr_addr = i_cmd.clear ? r_clr : r_pos;

    always_ff @(posedge i_clk) begin
        if (tag_we) r_tag_mem[wr_addr] <= tag_wd;
        r_rd_tag <= r_tag_mem[r_ix];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) r_key_mem[wr_addr] <= r_key;
        r_rd_key <= r_key_mem[r_ix];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) r_val_mem[wr_addr] <= val_wd;
        r_rd_val <= r_val_mem[r_ix];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out <= n_out;
    end

    assign o_sts.clear_last = (r_clr == LAST);
    assign o_sts.direct     = POW2;
    assign o_sts.mod_done   = (r_mcnt == MOD_LAST);
    assign o_sts.probe_stop = stop;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### sv/linear_probe_hash_map.sv
// Linear probing key-to-value map held in on-chip slot memories.
// Input channel: i_in_valid / o_in_stall carry one request word (command, key,
// key hash, value). Output channel: o_out_valid / i_out_stall carry one
// response word per request (status, found, value, slot, live entry count).
// A request is taken only while the block is idle; the response sits in an
// output register, so the next request is taken while it waits to be read.
// Steps per request: accept, probe the slots (one slot read per cycle from
// the slot memory port), then commit, with a power-of-two table. Other table
// sizes fold the hash into a start slot between accept and probe. A null key
// ends the probe without checking any slot.
// The response is valid the cycle after commit; if the receiver stalls, the
// commit step waits until the output register can take the new word.
// After reset the tag memory is swept to empty, one slot per cycle, over all
// TABLE_SIZE slots; requests are stalled meanwhile and the live entry
// count starts at zero.
module linear_probe_hash_map #(
    parameter int TABLE_SIZE = lphm_pkg::TABLE_SIZE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lphm_pkg::t_req i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output lphm_pkg::t_rsp o_out
);

    lphm_pkg::t_dp_cmd dp_cmd;
    lphm_pkg::t_dp_sts dp_sts;

    // The sequencer owns the order of steps; it never touches payload.
    lphm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the slot memories, probe registers and result word.
    lphm_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    // The sequencer issues at most one step per cycle.
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(dp_cmd))
        else $error("more than one datapath step at once");

    // A result is written only when the output register is free.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.commit |-> dp_sts.out_free)
        else $error("commit would overwrite a waiting response");

    // No response can appear in the cycle right after a request is taken.
    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid) |=> !o_out_valid)
        else $error("response appeared without a probe");

    // Requests are never taken during the reset sweep of the tag memory.
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.clear |-> o_in_stall)
        else $error("request taken while clearing");

endmodule

### test/tb_linear_probe_hash_map.sv
module tb_linear_probe_hash_map;
    timeunit 1ns;
    timeprecision 1ps;

    // The block is built at its default table size, so the mirror below uses the same size.
    localparam int SLOTS = lphm_pkg::TABLE_SIZE_DEF;

    // A command code that the block does not define. It must behave as a lookup.
    localparam logic [1:0] OP_UNDEF = 2'd3;

    // The limit allows for the slowest correct request plus the longest sender gap and
    // receiver stall for each of about 1950 requests, plus the tag sweep after reset.
    // The limit is several times that total.
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    // Number of keys in the pool that the random traffic works on.
    localparam int POOL_SIZE = 64;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    lphm_pkg::t_req i_in;
    logic           o_out_valid;
    logic           i_out_stall;
    lphm_pkg::t_rsp o_out;

    linear_probe_hash_map #(
        .TABLE_SIZE(SLOTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    // Mirror of the slot memories and of the live entry count. It is updated when a request
    // word is accepted, because the block handles requests strictly in order.
    logic [1:0]  mirror_tag [SLOTS];
    logic [31:0] mirror_key [SLOTS];
    logic [63:0] mirror_val [SLOTS];
    int unsigned mirror_live;

    // Response words that are still owed by the block, oldest first.
    lphm_pkg::t_rsp pending_rsp [$];

    int unsigned err_cnt;
    int unsigned cycle_cnt;
    bit          idle_en;

    logic [31:0] pool_key  [POOL_SIZE];
    logic [31:0] pool_hash [POOL_SIZE];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the mirror and return the response word it must produce.
    // The probe walks up from the hash slot and wraps around. It stops on the live slot
    // that holds the key, or on the first empty slot. The first tombstone it passes is
    // remembered, and a new key is inserted there.
    function automatic lphm_pkg::t_rsp apply_request(input lphm_pkg::t_req w);
        lphm_pkg::t_rsp r;
        int             spare;
        int             pos;
        int             ix;
        bit             hit;
        bit             stop;
        int unsigned    start;
        r = '0;
        r.status = lphm_pkg::ST_ABSENT;
        if (w.key_id == '0) begin
            r.status = lphm_pkg::ST_NULLKEY;
        end else begin
            spare = -1;
            pos   = -1;
            hit   = 1'b0;
            stop  = 1'b0;
            start = w.key_hash % SLOTS;
            for (int n = 0; n < SLOTS && !stop; n++) begin
                ix = (start + n) % SLOTS;
                if (mirror_tag[ix] == lphm_pkg::TAG_LIVE) begin
                    if (mirror_key[ix] == w.key_id) begin
                        hit  = 1'b1;
                        pos  = ix;
                        stop = 1'b1;
                    end
                end else if (mirror_tag[ix] == lphm_pkg::TAG_EMPTY) begin
                    pos  = (spare >= 0) ? spare : ix;
                    stop = 1'b1;
                end else if (spare < 0) begin
                    spare = ix;
                end
            end
            // The whole table was scanned with no empty slot. Only a tombstone can take a new key.
            if (!stop) pos = spare;

            case (w.cmd)
                lphm_pkg::OP_PUT: begin
                    if (hit) begin
                        mirror_val[pos] = w.value_in;
                        r.status     = lphm_pkg::ST_UPDATED;
                        r.found      = 1'b1;
                        r.slot_index = pos[7:0];
                    end else if (pos < 0) begin
                        r.status = lphm_pkg::ST_FULL;
                    end else begin
                        mirror_tag[pos] = lphm_pkg::TAG_LIVE;
                        mirror_key[pos] = w.key_id;
                        mirror_val[pos] = w.value_in;
                        mirror_live++;
                        r.status     = lphm_pkg::ST_INSERTED;
                        r.slot_index = pos[7:0];
                    end
                end
                lphm_pkg::OP_REMOVE: begin
                    if (hit) begin
                        mirror_tag[pos] = lphm_pkg::TAG_TOMB;
                        mirror_val[pos] = '0;
                        mirror_live--;
                        r.status     = lphm_pkg::ST_REMOVED;
                        r.found      = 1'b1;
                        r.slot_index = pos[7:0];
                    end
                end
                default: begin
                    // A lookup, and the undefined code that behaves as one.
                    if (hit) begin
                        r.status     = lphm_pkg::ST_UPDATED;
                        r.found      = 1'b1;
                        r.value_out  = mirror_val[pos];
                        r.slot_index = pos[7:0];
                    end
                end
            endcase
        end
        r.entry_count = mirror_live[8:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // Send one request word. Inputs change only at the falling edge. The word is accepted
    // at a rising edge where the block does not stall it. While gaps are enabled, a random
    // gap is sometimes inserted before the word. Valid then falls and rises on different
    // edges, so one time step never sees two assignments to it.
    task automatic send_request(input logic [1:0] cmd, input logic [31:0] key,
                                input logic [31:0] hash, input logic [63:0] val);
        lphm_pkg::t_req w;
        w.cmd      = cmd;
        w.key_id   = key;
        w.key_hash = hash;
        w.value_in = val;
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in       <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_rsp.push_back(apply_request(w));
    endtask

    // The null key must be ignored for every command code. A lookup on an empty map must
    // miss, and so must a remove.
    task automatic test_null_key;
        send_request(lphm_pkg::OP_LOOKUP, 32'h0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(lphm_pkg::OP_PUT,    32'h0, 32'h0000_0010, 64'h0123_4567_89AB_CDEF);
        send_request(lphm_pkg::OP_REMOVE, 32'h0, 32'h0000_0000, 64'h0);
        send_request(OP_UNDEF,            32'h0, 32'h8000_0000, 64'h8000_0000_0000_0000);
        send_request(lphm_pkg::OP_LOOKUP, 32'hA5A5_0001, 32'h0000_00FF, 64'h0);
        send_request(lphm_pkg::OP_REMOVE, 32'hA5A5_0001, 32'h0000_00FF, 64'h0);
    endtask

    // Several keys share a start slot at the top of the table, so their probe chain wraps
    // to slot 0. Removes in the middle of the chain leave tombstones. Later lookups must
    // probe past them, and new keys must land in the first one.
    task automatic test_probe_chain;
        send_request(lphm_pkg::OP_PUT,    32'hA5A5_0001, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(lphm_pkg::OP_PUT,    32'h5A5A_0002, 32'h1234_56FF, 64'h1111_2222_3333_4444);
        send_request(lphm_pkg::OP_PUT,    32'h0F0F_0003, 32'h0000_00FF, 64'h5555_AAAA_5555_AAAA);
        send_request(lphm_pkg::OP_LOOKUP, 32'h5A5A_0002, 32'h1234_56FF, 64'h0);
        send_request(OP_UNDEF,            32'h0F0F_0003, 32'h0000_00FF, 64'hDEAD_BEEF_DEAD_BEEF);
        send_request(lphm_pkg::OP_PUT,    32'hA5A5_0001, 32'hFFFF_FFFF, 64'h0);
        send_request(lphm_pkg::OP_LOOKUP, 32'hA5A5_0001, 32'hFFFF_FFFF, 64'h0);
        send_request(lphm_pkg::OP_REMOVE, 32'h5A5A_0002, 32'h1234_56FF, 64'h0);
        send_request(lphm_pkg::OP_LOOKUP, 32'h0F0F_0003, 32'h0000_00FF, 64'h0);
        send_request(lphm_pkg::OP_LOOKUP, 32'h5A5A_0002, 32'h1234_56FF, 64'h0);
        send_request(lphm_pkg::OP_PUT,    32'hF0F0_0004, 32'hABCD_00FF, 64'h0000_0000_0000_0001);
        send_request(lphm_pkg::OP_REMOVE, 32'hA5A5_0001, 32'hFFFF_FFFF, 64'h0);
        send_request(lphm_pkg::OP_PUT,    32'hFFFF_FFFF, 32'h0000_00FF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(lphm_pkg::OP_PUT,    32'h0000_0001, 32'h0000_0000, 64'h5555_5555_5555_5555);
        // A key that is looked up with a wrong hash starts in the wrong place and misses.
        send_request(lphm_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0000_0080, 64'h0);
        send_request(lphm_pkg::OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 64'h0);
        send_request(lphm_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_00FF, 64'h0);
        send_request(lphm_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_00FF, 64'h0);
    endtask

    // Random traffic on a pool of keys. Most start slots fall in a band that wraps around
    // the top of the table, so chains grow long and cross tombstones. Each key mostly keeps
    // its own hash, so puts, lookups and removes hit each other. Fresh random keys, stale
    // hashes and null keys are mixed in as noise.
    task automatic test_random_traffic(input int unsigned items);
        int unsigned done_cnt;
        int unsigned sel;
        int unsigned k;
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] hash;
        logic [63:0] val;
        for (int i = 0; i < POOL_SIZE; i++) begin
            do pool_key[i] = $urandom; while (pool_key[i] == '0);
            pool_hash[i] = $urandom;
            if ($urandom_range(0, 3) != 0) pool_hash[i][7:0] = 8'(240 + $urandom_range(0, 40));
        end
        done_cnt = 0;
        while (done_cnt < items) begin
            sel  = $urandom_range(0, 99);
            k    = $urandom_range(0, POOL_SIZE - 1);
            key  = pool_key[k];
            hash = pool_hash[k];
            val  = {$urandom, $urandom};
            case ($urandom_range(0, 15))
                0: val = '0;
                1: val = '1;
                default: ;
            endcase
            if (sel < 40) begin
                cmd = lphm_pkg::OP_PUT;
            end else if (sel < 65) begin
                cmd = lphm_pkg::OP_LOOKUP;
            end else if (sel < 85) begin
                cmd = lphm_pkg::OP_REMOVE;
            end else if (sel < 90) begin
                cmd = OP_UNDEF;
            end else if (sel < 96) begin
                cmd  = 2'($urandom_range(0, 3));
                key  = $urandom;
                hash = $urandom;
            end else begin
                cmd = 2'($urandom_range(0, 3));
                key = '0;
            end
            if ($urandom_range(0, 19) == 0) hash = $urandom;
            send_request(cmd, key, hash, val);
            if (key != '0) done_cnt++;
        end
    endtask

    // Fill every slot. Then a put of a new key must report a full table, and a lookup must
    // miss after a scan of the whole table. After one remove, a new key must take that
    // tombstone once the scan has found no empty slot.
    task automatic test_table_full;
        int unsigned n;
        logic [31:0] spare_hash;
        n = 0;
        spare_hash = $urandom;
        while (mirror_live < SLOTS) begin
            send_request(lphm_pkg::OP_PUT, 32'h8000_0000 | n, n, {$urandom, $urandom});
            n++;
        end
        send_request(lphm_pkg::OP_PUT,    32'h7FFF_FFFF, spare_hash, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(lphm_pkg::OP_LOOKUP, 32'h7FFF_FFFF, spare_hash, 64'h0);
        send_request(lphm_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0, 64'h0);
        send_request(lphm_pkg::OP_REMOVE, 32'h8000_0000, 32'h0, 64'h0);
        send_request(lphm_pkg::OP_PUT,    32'h7FFF_FFFF, spare_hash, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(lphm_pkg::OP_PUT,    32'h7FFF_FFFE, spare_hash, 64'h1);
        send_request(lphm_pkg::OP_LOOKUP, 32'h7FFF_FFFF, spare_hash, 64'h0);
        send_request(lphm_pkg::OP_PUT,    32'h7FFF_FFFF, spare_hash, 64'h0);
        send_request(lphm_pkg::OP_REMOVE, 32'h8000_0000, 32'h0, 64'h0);
        send_request(lphm_pkg::OP_PUT,    32'h0, spare_hash, 64'h0);
    endtask

    // The receiver stalls in random bursts. At most one assignment to the stall is made
    // per falling edge.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_en && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    // Every response word taken at a rising edge is compared with the oldest one owed.
    always @(posedge i_clk) begin : rsp_check
        lphm_pkg::t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: response word with none expected, actual %0h", $time, o_out);
                err_cnt++;
            end else begin
                want = pending_rsp.pop_front();
                check_field("status",      want.status,      o_out.status);
                check_field("found",       want.found,       o_out.found);
                check_field("value_out",   want.value_out,   o_out.value_out);
                check_field("slot_index",  want.slot_index,  o_out.slot_index);
                check_field("entry_count", want.entry_count, o_out.entry_count);
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d response words owed", $time, pending_rsp.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        idle_en    = 1'b1;
        err_cnt    = 0;
        cycle_cnt  = 0;
        mirror_live = 0;
        foreach (mirror_tag[i]) begin
            mirror_tag[i] = lphm_pkg::TAG_EMPTY;
            mirror_key[i] = '0;
            mirror_val[i] = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The block stalls requests during its tag sweep after reset. The sender simply
        // waits out that stall.
        test_null_key();
        test_probe_chain();
        test_random_traffic(1650);
        // The last part runs with no gaps and no stalls.
        idle_en = 1'b0;
        test_table_full();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        // Quiet period to catch any response word that was not asked for.
        repeat (300) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
